/* rtl/core/csv_field_unquote_filter_defines.svh */
// Assertion macros shared by the RTL files of the CSV field unquote filter.
// Each macro asserts a property on the rising edge of i_clk, with the
// synchronous reset i_rst_n masking the check while it is low.
`ifndef CSV_FIELD_UNQUOTE_FILTER_DEFINES_SVH
`define CSV_FIELD_UNQUOTE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: cond must hold whenever trig holds.
`define CSVFU_ASSERT_IMP(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);
// Next-cycle implication: cond must hold in the cycle after trig.
`define CSVFU_ASSERT_NXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define CSVFU_ASSERT_IMP(label, trig, cond, msg)
`define CSVFU_ASSERT_NXT(label, trig, cond, msg)
`endif

`endif

/* rtl/core/csvfu_pkg.sv */
package csvfu_pkg;

    localparam int unsigned STATUS_NUM = 5;
    localparam int unsigned LENGTH_CAP = 20;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic [7:0] t_char;

    localparam t_char CHAR_NUL     = 8'h00;
    localparam t_char CHAR_NEWLINE = 8'h0A;
    localparam t_char CHAR_SPACE   = 8'h20;
    localparam t_char CHAR_QUOTE   = 8'h22;
    localparam t_char CHAR_COMMA   = 8'h2C;

    // Register indexes, taken from paddr above the byte offset.
    localparam logic REG_COLUMN_COUNT = 1'b0;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_QHELD,
        MODE_STOPPED
    } t_mode;

    typedef struct packed {
        t_char out_byte;
        logic  byte_valid;
        logic  finished;
    } t_result;

    typedef struct packed {
        t_mode mode;
        logic  stopped;
    } t_parse_status;

    // Status strings, right-justified in a fixed-width vector: the first
    // character of a string sits in the highest used byte.
    localparam logic [LENGTH_CAP*8-1:0] STATUS_TEXT [STATUS_NUM] = '{
        "not a real question",
        "not constructive",
        "off topic",
        "open",
        "too localized"
    };

    localparam logic [LEN_W-1:0] STATUS_LEN [STATUS_NUM] = '{
        5'd19, 5'd16, 5'd9, 5'd4, 5'd13
    };

    // Character at position pos of status string idx; zero past its end.
    function automatic t_char status_char(input int unsigned idx,
                                          input logic [LEN_W-1:0] pos);
        logic [LEN_W-1:0]          sel;
        logic [LENGTH_CAP*8-1:0]   text;
        text = STATUS_TEXT[idx];
        sel  = (pos < STATUS_LEN[idx]) ? (STATUS_LEN[idx] - 5'd1 - pos) : '0;
        return (pos < STATUS_LEN[idx]) ? text[sel*8 +: 8] : CHAR_NUL;
    endfunction

endpackage

/* rtl/core/csvfu_match.sv */
module csvfu_match (
    input  logic [csvfu_pkg::STATUS_NUM-1:0] i_match,
    input  logic [csvfu_pkg::LEN_W-1:0]      i_length,
    input  csvfu_pkg::t_char                 i_char,
    output logic [csvfu_pkg::STATUS_NUM-1:0] o_match_next,
    output logic                             o_hit
);
    import csvfu_pkg::*;

    // A status string stays a candidate while the field text is a prefix
    // of it; the field matches when a candidate has exactly its length.
    always_comb begin
        o_match_next = i_match;
        o_hit        = 1'b0;
        for (int unsigned i = 0; i < STATUS_NUM; i++) begin
            if (i_length >= STATUS_LEN[i] || status_char(i, i_length) != i_char) begin
                o_match_next[i] = 1'b0;
            end
            if (i_match[i] && i_length == STATUS_LEN[i]) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

/* rtl/core/csvfu_parser.sv */
module csvfu_parser #(
    parameter int unsigned MAX_COLUMNS = 64,
    parameter int unsigned CIDX_W      = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  csvfu_pkg::t_char               i_byte,
    input  logic                           i_eoi,
    input  logic [csvfu_pkg::COUNT_W-1:0]  i_column_count,
    output logic                           o_result_valid,
    output csvfu_pkg::t_result             o_result,
    output csvfu_pkg::t_parse_status       o_status
);
    import csvfu_pkg::*;

    localparam logic [8:0] MAX_COLS = 9'(MAX_COLUMNS);

    t_mode                  r_mode, n_mode;
    logic [CIDX_W-1:0]      r_col, n_col;
    logic [LEN_W-1:0]       r_length, n_length;
    logic [STATUS_NUM-1:0]  r_match, n_match;

    logic                   do_emit;
    logic                   do_end;
    t_char                  emit_char;
    logic [STATUS_NUM-1:0]  match_next;
    logic                   hit;
    logic [8:0]             cols_used;
    logic                   last_col;
    logic                   is_sep;

    csvfu_match u_match (
        .i_match      (r_match),
        .i_length     (r_length),
        .i_char       (emit_char),
        .o_match_next (match_next),
        .o_hit        (hit)
    );

    always_comb begin
        cols_used = {2'b00, i_column_count};
        if (cols_used == 9'd0) begin
            cols_used = 9'd1;
        end
        if (cols_used > MAX_COLS) begin
            cols_used = MAX_COLS;
        end
        last_col = (9'(r_col) + 9'd1) >= cols_used;
        is_sep   = (i_byte == CHAR_COMMA) || (i_byte == CHAR_NEWLINE) ||
                   (i_byte == CHAR_NUL);
        // A comma or newline is only ever emitted inside quotes, as a space.
        emit_char = ((i_byte == CHAR_COMMA) || (i_byte == CHAR_NEWLINE)) ?
                    CHAR_SPACE : i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_START;
            r_col    <= '0;
            r_length <= '0;
            r_match  <= '1;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_col    <= n_col;
            r_length <= n_length;
            r_match  <= n_match;
        end
    end

    always_comb begin
        n_mode         = r_mode;
        n_col          = r_col;
        n_length       = r_length;
        n_match        = r_match;
        do_emit        = 1'b0;
        do_end         = 1'b0;
        o_result_valid = 1'b0;
        o_result       = '{out_byte: CHAR_NUL, byte_valid: 1'b0, finished: 1'b0};

        if (r_mode != MODE_STOPPED && i_eoi) begin
            n_mode         = MODE_STOPPED;
            o_result_valid = 1'b1;
            o_result       = '{out_byte: CHAR_NUL, byte_valid: 1'b0, finished: 1'b1};
        end else begin
            case (r_mode)
                MODE_START: begin
                    if (i_byte == CHAR_QUOTE) begin
                        n_mode = MODE_QUOTED;
                    end else if (is_sep) begin
                        do_end = 1'b1;
                    end else begin
                        n_mode  = MODE_PLAIN;
                        do_emit = 1'b1;
                    end
                end
                MODE_PLAIN: begin
                    if (is_sep) begin
                        do_end = 1'b1;
                    end else begin
                        do_emit = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (i_byte == CHAR_QUOTE) begin
                        n_mode = MODE_QHELD;
                    end else if (i_byte == CHAR_NUL) begin
                        do_end = 1'b1;
                    end else begin
                        do_emit = 1'b1;
                    end
                end
                MODE_QHELD: begin
                    if (i_byte == CHAR_QUOTE) begin
                        n_mode = MODE_QUOTED;
                    end else begin
                        do_end = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (do_emit) begin
                n_match        = match_next;
                n_length       = (r_length < LEN_W'(LENGTH_CAP)) ? r_length + 5'd1 : r_length;
                o_result_valid = 1'b1;
                o_result       = '{out_byte: emit_char, byte_valid: 1'b1, finished: 1'b0};
            end

            if (do_end) begin
                o_result_valid = 1'b1;
                if (!last_col) begin
                    n_col    = r_col + CIDX_W'(1);
                    n_mode   = MODE_START;
                    n_length = '0;
                    n_match  = '1;
                    o_result = '{out_byte: CHAR_COMMA, byte_valid: 1'b1, finished: 1'b0};
                end else if (hit) begin
                    n_col    = '0;
                    n_mode   = MODE_START;
                    n_length = '0;
                    n_match  = '1;
                    o_result = '{out_byte: CHAR_NEWLINE, byte_valid: 1'b1, finished: 1'b0};
                end else begin
                    n_mode   = MODE_STOPPED;
                    o_result = '{out_byte: CHAR_NUL, byte_valid: 1'b0, finished: 1'b1};
                end
            end
        end

        o_status.mode    = r_mode;
        o_status.stopped = (r_mode == MODE_STOPPED);
    end

endmodule

/* rtl/core/csv_field_unquote_filter.sv */
// CSV field unquote filter.
// The input channel (i_in_valid / o_in_ready) carries one beat per raw byte
// of a CSV record body, with i_end_of_input marking the end of the stream.
// The output channel (o_out_valid / i_out_ready) carries at most one beat per
// input beat: a field character, a space, a comma between columns, a newline
// after a record whose last field names a known status, or a finished beat.
// Input bytes that emit nothing (quotes, or anything after the block stops)
// produce no output beat.
// An input beat is captured in an input register; when the parser steps, it
// decides the beat's result into the output register, which drives
// o_out_valid.
// One byte is taken per cycle as long as the receiver keeps up; the parser
// state update is the loop that sets this rate.
// When the receiver stalls, the output register holds its beat and the input
// register fills; o_in_ready drops only when both are occupied.
// After reset the column count is 1, the parser waits at the start of a
// field, and both registers are empty. The column count is written through
// the APB port at byte address 0; the user must do so only while the block
// is idle, which the block itself does not enforce.
module csv_field_unquote_filter #(
    parameter int unsigned MAX_COLUMNS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  csvfu_pkg::t_char                  i_in_byte,
    input  logic                              i_end_of_input,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output csvfu_pkg::t_char                  o_out_byte,
    output logic                              o_byte_valid,
    output logic                              o_finished,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csvfu_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [csvfu_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [csvfu_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import csvfu_pkg::*;

    `include "csv_field_unquote_filter_defines.svh"

    // Column index width follows the largest column count supported.
    localparam int unsigned CIDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [COUNT_W-1:0] r_column_count;

    logic               r_s1_valid;
    t_char              r_s1_byte;
    logic               r_s1_eoi;

    logic               r_out_valid;
    t_result            r_out;

    logic               step;
    logic               res_valid;
    t_result            res;
    t_parse_status      status;
    logic               cfg_write;

    // Configuration port: zero wait states; the register index sits above
    // the two byte-offset bits of paddr.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= COUNT_W'(1);
        end else if (cfg_write && paddr[CFG_ADDR_W-1] == REG_COLUMN_COUNT) begin
            r_column_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[CFG_ADDR_W-1] == REG_COLUMN_COUNT) begin
            prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, r_column_count};
        end
    end

    // The held byte moves through the parser whenever the output register
    // is empty or is being emptied in this cycle.
    assign step       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_byte <= i_in_byte;
            r_s1_eoi  <= i_end_of_input;
        end
    end

    csvfu_parser #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CIDX_W      (CIDX_W)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_byte         (r_s1_byte),
        .i_eoi          (r_s1_eoi),
        .i_column_count (r_column_count),
        .o_result_valid (res_valid),
        .o_result       (res),
        .o_status       (status)
    );

    // Output register: loaded on every parser step (a step may produce no
    // beat), otherwise cleared once the receiver takes the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_byte_valid = r_out.byte_valid;
    assign o_finished   = r_out.finished;

    // Once stopped, the parser stays stopped until reset.
    `CSVFU_ASSERT_NXT(a_stop_sticky, status.stopped, status.stopped,
        "parser left the stopped mode")
    // An end-of-input byte reaching a running parser yields a finished beat.
    `CSVFU_ASSERT_NXT(a_eoi_finishes, step && r_s1_eoi && !status.stopped,
        r_out_valid && r_out.finished && !r_out.byte_valid,
        "end of input did not produce a finished beat")
    // A stopped parser produces no further beats.
    `CSVFU_ASSERT_IMP(a_stopped_silent, step && status.stopped, !res_valid,
        "stopped parser produced a beat")
    // Input backpressure only when both registers are occupied and stalled.
    `CSVFU_ASSERT_IMP(a_ready_cause, !o_in_ready,
        r_s1_valid && r_out_valid && !i_out_ready,
        "input stalled without a full pipeline")

endmodule

/* bench/tb_csv_field_unquote_filter.sv */
module tb_csv_field_unquote_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import csvfu_pkg::*;

    localparam int unsigned MAX_COLS = 64;

    // The column count is register 0, so it sits at byte address 0.
    localparam logic [CFG_ADDR_W-1:0] COLUMN_ADDR = {REG_COLUMN_COUNT, 2'b00};

    // Cycles to wait for the last outstanding beat before calling it lost.
    localparam int unsigned DRAIN_LIMIT = 20000;

    // Quiet cycles after the last expected beat.  A byte passes the input and
    // output registers on its way through, and a quote byte may still be in
    // flight with no beat of its own.
    localparam int unsigned QUIET_CYCLES = 8;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_char                  i_in_byte;
    logic                   i_end_of_input;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_char                  o_out_byte;
    logic                   o_byte_valid;
    logic                   o_finished;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    csv_field_unquote_filter #(
        .MAX_COLUMNS (MAX_COLS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_finished     (o_finished),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model.  It mirrors the block's state and is advanced once for
    // every input beat that the block accepts.
    // ------------------------------------------------------------------
    string status_words [5] = '{
        "not a real question", "not constructive", "off topic", "open", "too localized"
    };

    t_mode        prs_mode;
    int unsigned  prs_col;
    int unsigned  prs_len;
    logic [4:0]   prs_hits;
    logic [6:0]   cfg_columns;

    // Output beats that the model has predicted and the block has not yet sent.
    t_result      unquoted_due [$];

    int unsigned  mismatch_count = 0;
    int unsigned  beats_in = 0;
    int unsigned  beats_out = 0;
    int unsigned  records_done = 0;

    // Traffic shaping shared by the sender, the receiver and the tests.
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct = 0;
    int unsigned  hold_left = 0;

    function automatic void reset_parser();
        prs_mode    = MODE_START;
        prs_col     = 0;
        prs_len     = 0;
        prs_hits    = '1;
        cfg_columns = 7'd1;
    endfunction

    // A zero count behaves as one column, anything past the maximum as the maximum.
    function automatic int unsigned columns_used();
        int unsigned n;
        n = cfg_columns;
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_COLS) begin
            n = MAX_COLS;
        end
        return n;
    endfunction

    function automatic bit ends_plain(input t_char c);
        return c == CHAR_COMMA || c == CHAR_NEWLINE || c == CHAR_NUL;
    endfunction

    // Emits one character of field text and narrows the set of status strings
    // that the field could still turn out to be.
    function automatic t_result emit_text(input t_char c);
        t_result r;
        r = '0;
        for (int i = 0; i < 5; i++) begin
            if (prs_hits[i] && (prs_len >= status_words[i].len() ||
                                t_char'(status_words[i][prs_len]) != c)) begin
                prs_hits[i] = 1'b0;
            end
        end
        if (prs_len < LENGTH_CAP) begin
            prs_len++;
        end
        r.out_byte   = c;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic t_result close_field();
        t_result r;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        if (prs_col + 1 < columns_used()) begin
            prs_col++;
            prs_mode     = MODE_START;
            prs_len      = 0;
            prs_hits     = '1;
            r.out_byte   = CHAR_COMMA;
            r.byte_valid = 1'b1;
            return r;
        end
        for (int i = 0; i < 5; i++) begin
            if (prs_hits[i] && prs_len == status_words[i].len()) begin
                hit = 1'b1;
            end
        end
        if (!hit) begin
            prs_mode   = MODE_STOPPED;
            r.finished = 1'b1;
            return r;
        end
        prs_col      = 0;
        prs_mode     = MODE_START;
        prs_len      = 0;
        prs_hits     = '1;
        r.out_byte   = CHAR_NEWLINE;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    // Advances the model by one input beat; returns 1 when the beat yields an output beat.
    function automatic bit parse_byte(input t_char c, input logic eoi, output t_result r);
        r = '0;
        if (prs_mode == MODE_STOPPED) begin
            return 1'b0;
        end
        if (eoi) begin
            prs_mode   = MODE_STOPPED;
            r.finished = 1'b1;
            return 1'b1;
        end
        case (prs_mode)
            MODE_START: begin
                if (c == CHAR_QUOTE) begin
                    prs_mode = MODE_QUOTED;
                    return 1'b0;
                end
                if (ends_plain(c)) begin
                    r = close_field();
                end else begin
                    prs_mode = MODE_PLAIN;
                    r = emit_text(c);
                end
            end
            MODE_PLAIN: begin
                r = ends_plain(c) ? close_field() : emit_text(c);
            end
            MODE_QUOTED: begin
                if (c == CHAR_QUOTE) begin
                    prs_mode = MODE_QHELD;
                    return 1'b0;
                end
                if (c == CHAR_NUL) begin
                    r = close_field();
                end else if (c == CHAR_COMMA || c == CHAR_NEWLINE) begin
                    r = emit_text(CHAR_SPACE);
                end else begin
                    r = emit_text(c);
                end
            end
            default: begin
                // A quote is held: a second one is an escaped quote and both
                // vanish, anything else closes the field.
                if (c == CHAR_QUOTE) begin
                    prs_mode = MODE_QUOTED;
                    return 1'b0;
                end
                r = close_field();
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and the output checker.
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Every output beat is compared with the oldest prediction.  Sampling
    // happens at the rising edge, where the handshake is decided.
    always @(posedge i_clk) begin : check_output
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            beats_out++;
            if (unquoted_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat byte=%h valid=%b finished=%b",
                                        o_out_byte, o_byte_valid, o_finished));
            end else begin
                want = unquoted_due.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    flag_mismatch($sformatf("out_byte %h, expected %h",
                                            o_out_byte, want.out_byte));
                end
                if (o_byte_valid !== want.byte_valid) begin
                    flag_mismatch($sformatf("byte_valid %b, expected %b",
                                            o_byte_valid, want.byte_valid));
                end
                if (o_finished !== want.finished) begin
                    flag_mismatch($sformatf("finished %b, expected %b",
                                            o_finished, want.finished));
                end
                if (want.byte_valid && want.out_byte == CHAR_NEWLINE) begin
                    records_done++;
                end
            end
        end
    end

    // The receiver either holds off for a counted stretch or stalls at random
    // with the probability of the current phase.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers one beat and waits for its acceptance.  Valid is left high on
    // return, so the caller must follow with another beat or with settle().
    task automatic send_beat(input t_char c, input logic eoi);
        int unsigned gap;
        t_result     r;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        @(negedge i_clk);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_byte      <= c;
        i_end_of_input <= eoi;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
        beats_in++;
        if (parse_byte(c, eoi, r)) begin
            unquoted_due.push_back(r);
        end
    endtask

    // Stops offering beats and waits until every predicted beat has come out,
    // plus a few quiet cycles for any byte still inside the pipeline.
    task automatic settle();
        int unsigned waited;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (unquoted_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (unquoted_due.size() != 0) begin
            flag_mismatch($sformatf("%0d predicted beats never arrived", unquoted_due.size()));
            unquoted_due.delete();
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Writes the column count while the block is idle and reads it back.
    task automatic set_columns(input int unsigned value);
        logic [CFG_DATA_W-1:0] got;
        settle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLUMN_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        cfg_columns = value[6:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== (value & 32'h7F)) begin
            flag_mismatch($sformatf("column count reads %h, expected %h", got, value & 32'h7F));
        end
    endtask

    // Random characters, weighted toward the ones the parser treats specially.
    function automatic t_char pick_char();
        case ($urandom_range(0, 9))
            0:       return CHAR_COMMA;
            1:       return CHAR_NEWLINE;
            2:       return CHAR_QUOTE;
            3:       return CHAR_SPACE;
            default: return t_char'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic t_char pick_end();
        case ($urandom_range(0, 2))
            0:       return CHAR_COMMA;
            1:       return CHAR_NEWLINE;
            default: return CHAR_NUL;
        endcase
    endfunction

    // Unquoted text of n characters: no separator, and no quote up front.
    task automatic send_plain_run(input int unsigned n);
        t_char c;
        for (int k = 0; k < n; k++) begin
            do begin
                c = pick_char();
            end while (ends_plain(c) || (k == 0 && c == CHAR_QUOTE));
            send_beat(c, 1'b0);
        end
    endtask

    // A quoted field ends either on a bare zero byte or on a closing quote
    // followed by any byte that is not a quote.
    task automatic close_quoted();
        t_char c;
        if ($urandom_range(0, 3) == 0) begin
            send_beat(CHAR_NUL, 1'b0);
        end else begin
            send_beat(CHAR_QUOTE, 1'b0);
            case ($urandom_range(0, 3))
                0:       c = CHAR_COMMA;
                1:       c = CHAR_NEWLINE;
                2:       c = CHAR_NUL;
                default: begin
                    do begin
                        c = t_char'($urandom_range(1, 255));
                    end while (c == CHAR_QUOTE);
                end
            endcase
            send_beat(c, 1'b0);
        end
    endtask

    // Any field of a column other than the last: empty, unquoted or quoted
    // with random content.  Lengths are mostly short, now and then past the
    // length cap.
    task automatic send_free_field();
        int unsigned kind;
        int unsigned n;
        t_char       c;
        kind = $urandom_range(0, 9);
        n    = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        if (kind == 0) begin
            send_beat(pick_end(), 1'b0);
        end else if (kind < 5) begin
            send_plain_run(n);
            send_beat(pick_end(), 1'b0);
        end else begin
            send_beat(CHAR_QUOTE, 1'b0);
            for (int k = 0; k < n; k++) begin
                c = pick_char();
                send_beat(c, 1'b0);
                if (c == CHAR_QUOTE) begin
                    send_beat(CHAR_QUOTE, 1'b0);
                end
            end
            close_quoted();
        end
    endtask

    // The last column carries a status word.  When quoted, its spaces may be
    // spelled as commas or newlines and escaped quote pairs may be slipped in,
    // all of which must still unquote to the exact word.
    task automatic send_status_field();
        string w;
        t_char c;
        w = status_words[$urandom_range(0, 4)];
        if ($urandom_range(0, 1) == 0) begin
            for (int k = 0; k < w.len(); k++) begin
                send_beat(t_char'(w[k]), 1'b0);
            end
            send_beat(pick_end(), 1'b0);
        end else begin
            send_beat(CHAR_QUOTE, 1'b0);
            for (int k = 0; k < w.len(); k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_beat(CHAR_QUOTE, 1'b0);
                    send_beat(CHAR_QUOTE, 1'b0);
                end
                c = t_char'(w[k]);
                if (c == CHAR_SPACE) begin
                    case ($urandom_range(0, 2))
                        0:       c = CHAR_COMMA;
                        1:       c = CHAR_NEWLINE;
                        default: ;
                    endcase
                end
                send_beat(c, 1'b0);
            end
            close_quoted();
        end
    endtask

    // Picks the kind of field from where the model says the record stands.
    task automatic send_next_field();
        if (prs_col + 1 >= columns_used()) begin
            send_status_field();
        end else begin
            send_free_field();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-built records over two columns: a quoted field with a comma, a
    // newline and an escaped quote; an empty field; a quoted status closed by
    // a zero byte; the extreme byte value inside unquoted text; a quoted status
    // closed by a quote and a stray byte.  Then a zero column count, which must
    // behave as a single column.
    task automatic test_directed();
        t_char seq [$];
        set_columns(2);
        seq = '{CHAR_QUOTE, "a", CHAR_COMMA, CHAR_QUOTE, CHAR_QUOTE, CHAR_NEWLINE,
                CHAR_QUOTE, CHAR_COMMA,
                "o", "p", "e", "n", CHAR_NEWLINE,
                CHAR_COMMA,
                CHAR_QUOTE, "o", "p", "e", "n", CHAR_NUL,
                8'hFF, CHAR_QUOTE, CHAR_NUL,
                CHAR_QUOTE, "o", "p", "e", "n", CHAR_QUOTE, 8'h7F};
        foreach (seq[k]) begin
            send_beat(seq[k], 1'b0);
        end
        set_columns(0);
        seq = '{"o", "p", "e", "n", CHAR_COMMA};
        foreach (seq[k]) begin
            send_beat(seq[k], 1'b0);
        end
    endtask

    // The count is lowered in the middle of a record, below the column the
    // parser is in; that column must then be treated as the last one.
    task automatic test_column_shrink();
        set_columns(6);
        repeat (3) send_free_field();
        set_columns(2);
        send_next_field();
        send_next_field();
    endtask

    task automatic test_random_stream(input int unsigned cols, input int unsigned beats,
                                      input int unsigned s_pct, input int unsigned r_pct);
        int unsigned start;
        set_columns(cols);
        send_idle_pct = s_pct;
        stall_pct     = r_pct;
        start         = beats_in;
        while (beats_in - start < beats) begin
            send_next_field();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats back to back, so both pipeline registers fill and the
    // input side has to stall.
    task automatic test_backpressure();
        int unsigned start;
        set_columns(4);
        @(posedge i_clk);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 250;
        start         = beats_in;
        while (beats_in - start < 80) begin
            send_next_field();
        end
    endtask

    // The block is stopped for good, either by a last field that names no
    // status or by the end marker in the middle of a field.  Reset comes only
    // once, so this closes the run.  Beats after the stop, end markers too,
    // must be swallowed without a trace.
    task automatic test_stop();
        string w;
        send_idle_pct = 24;
        stall_pct     = 24;
        if ($urandom_range(0, 1) == 0) begin
            while (prs_col + 1 < columns_used()) begin
                send_free_field();
            end
            case ($urandom_range(0, 2))
                0: ;
                1: begin
                    // A status word with one character too many.
                    w = status_words[$urandom_range(0, 4)];
                    for (int k = 0; k < w.len(); k++) begin
                        send_beat(t_char'(w[k]), 1'b0);
                    end
                    send_beat("s", 1'b0);
                end
                default: send_plain_run(25);
            endcase
            send_beat(pick_end(), 1'b0);
        end else begin
            send_plain_run($urandom_range(0, 5));
            send_beat(t_char'($urandom_range(0, 255)), 1'b1);
        end
        repeat (11) send_beat(t_char'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_beat(t_char'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_byte      = '0;
        i_end_of_input = 1'b0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        reset_parser();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_column_shrink();
        // Phases of traffic: steady, idle sender, stalling receiver, both.
        // The widest count is written as 127 to show it behaves as the maximum.
        test_random_stream(3, 300, 0, 0);
        test_random_stream(1, 300, 48, 0);
        test_random_stream(127, 400, 0, 48);
        test_random_stream(2, 270, 24, 24);
        test_backpressure();
        test_stop();
        settle();

        $display("Run covered %0d input beats and %0d output beats, %0d records closed by a status.",
                 beats_in, beats_out, records_done);
        $display("Column counts from 0 to 127 were used under several traffic mixes, ending stopped.");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: a correct run takes far less than this.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
